[hdl/bscu_pkg.sv]
// ----------------------------------------------------------------------------
// bscu_pkg
// Shared widths, codes, types and constants of the barometric sensor
// compensation unit.
// ----------------------------------------------------------------------------
package bscu_pkg;

    localparam int RAW_W     = 24;
    localparam int TEMP_W    = 20;
    localparam int PRESS_W   = 32;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DT_W      = 26;
    localparam int TFO_W     = 19;
    localparam int MUL_W     = 27;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int WIDE_W    = 40;
    localparam int ACC_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_SENS_COEF       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_COEF        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TEMP_COEF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP_COEF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE_COEF = 3'd5;

    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;
    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    localparam logic signed [TFO_W-1:0]   TEMP_REF  = 19'sd2000;
    localparam logic signed [PRESS_W-1:0] PRESS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PRESS_W-1:0] PRESS_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [COEF_W-1:0] sens_coef;
        logic [COEF_W-1:0] off_coef;
        logic [COEF_W-1:0] sens_temp_coef;
        logic [COEF_W-1:0] off_temp_coef;
        logic [COEF_W-1:0] ref_temp_coef;
        logic [COEF_W-1:0] temp_slope_coef;
    } coef_set_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TMUL,
        ST_TEMP,
        ST_OFFMUL,
        ST_OFF,
        ST_SENS,
        ST_AUX,
        ST_CORR,
        ST_PHI,
        ST_PLO,
        ST_PACC,
        ST_PSUB,
        ST_PRES,
        ST_OUT
    } state_t;

endpackage

[hdl/bscu_if.sv]
// ----------------------------------------------------------------------------
// bscu_if
// Valid/ready channels for raw conversions in and compensated results out.
// ----------------------------------------------------------------------------
interface bscu_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [bscu_pkg::RAW_W-1:0]   raw_value;

    modport source (output valid, output cmd, output raw_value, input ready);
    modport sink   (input valid, input cmd, input raw_value, output ready);
endinterface

interface bscu_out_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [bscu_pkg::TEMP_W-1:0]  temperature;
    logic signed [bscu_pkg::PRESS_W-1:0] pressure;
    logic                                no_temperature_yet;

    modport source (output valid, output kind, output temperature, output pressure,
                    output no_temperature_yet, input ready);
    modport sink   (input valid, input kind, input temperature, input pressure,
                    input no_temperature_yet, output ready);
endinterface

[hdl/bscu_coef_regs.sv]
// ----------------------------------------------------------------------------
// bscu_coef_regs
// Calibration coefficient register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bscu_coef_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [bscu_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [bscu_pkg::COEF_W-1:0]         wr_data,
    output bscu_pkg::coef_set_t                 coef
);

    bscu_pkg::coef_set_t coef_reg;
    bscu_pkg::coef_set_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            case (wr_index)
                bscu_pkg::REG_SENS_COEF:       coef_next.sens_coef       = wr_data;
                bscu_pkg::REG_OFF_COEF:        coef_next.off_coef        = wr_data;
                bscu_pkg::REG_SENS_TEMP_COEF:  coef_next.sens_temp_coef  = wr_data;
                bscu_pkg::REG_OFF_TEMP_COEF:   coef_next.off_temp_coef   = wr_data;
                bscu_pkg::REG_REF_TEMP_COEF:   coef_next.ref_temp_coef   = wr_data;
                bscu_pkg::REG_TEMP_SLOPE_COEF: coef_next.temp_slope_coef = wr_data;
                default:                       coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

[hdl/bscu_mul.sv]
// ----------------------------------------------------------------------------
// bscu_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module bscu_mul (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [bscu_pkg::MUL_W-1:0]    a,
    input  logic signed [bscu_pkg::MUL_W-1:0]    b,
    output logic signed [bscu_pkg::PROD_W-1:0]   prod
);

    logic signed [bscu_pkg::PROD_W-1:0] prod_reg;
    logic signed [bscu_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = prod_reg;
        if (en)
        begin
            prod_next = a * b;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[hdl/bscu_core.sv]
// ----------------------------------------------------------------------------
// bscu_core
// Sequencer and datapath: first and second order compensation steps issued
// one by one through the shared multiplier.
// ----------------------------------------------------------------------------
module bscu_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bscu_pkg::coef_set_t  coef,
    bscu_in_if.sink              sample,
    bscu_out_if.source           result
);

    localparam int MW = bscu_pkg::MUL_W;
    localparam int PW = bscu_pkg::PROD_W;
    localparam int WW = bscu_pkg::WIDE_W;
    localparam int AW = bscu_pkg::ACC_W;
    localparam int TW = bscu_pkg::TEMP_W;
    localparam int DW = bscu_pkg::DT_W;
    localparam int FW = bscu_pkg::TFO_W;
    localparam int CW = bscu_pkg::COEF_W;
    localparam int RW = bscu_pkg::RAW_W;
    localparam int HW = WW / 2;

    bscu_pkg::state_t state_reg;
    bscu_pkg::state_t state_next;

    logic signed [DW-1:0]   temp_delta_reg;
    logic signed [DW-1:0]   temp_delta_next;
    logic signed [FW-1:0]   temp_first_order_reg;
    logic signed [FW-1:0]   temp_first_order_next;
    logic                   temp_seen_reg;
    logic                   temp_seen_next;
    logic [RW-1:0]          raw_reg;
    logic [RW-1:0]          raw_next;
    logic signed [WW-1:0]   off_reg;
    logic signed [WW-1:0]   off_next;
    logic signed [WW-1:0]   sens_reg;
    logic signed [WW-1:0]   sens_next;
    logic [WW-1:0]          aux5_reg;
    logic [WW-1:0]          aux5_next;
    logic signed [TW-1:0]   t2_reg;
    logic signed [TW-1:0]   t2_next;
    logic signed [AW-1:0]   acc_reg;
    logic signed [AW-1:0]   acc_next;
    logic                   out_kind_reg;
    logic                   out_kind_next;
    logic signed [TW-1:0]   out_temp_reg;
    logic signed [TW-1:0]   out_temp_next;
    logic signed [bscu_pkg::PRESS_W-1:0] out_press_reg;
    logic signed [bscu_pkg::PRESS_W-1:0] out_press_next;
    logic                   out_flag_reg;
    logic                   out_flag_next;

    logic                   mul_en;
    logic signed [MW-1:0]   mul_a;
    logic signed [MW-1:0]   mul_b;
    logic signed [PW-1:0]   prod;

    logic                   accept;
    logic                   cold;
    logic signed [MW-1:0]   dt_ext;
    logic signed [TW-1:0]   dev;
    logic signed [FW-1:0]   t_new;
    logic                   p_fits;

    assign accept = sample.valid && sample.ready;
    assign cold   = temp_first_order_reg < bscu_pkg::TEMP_REF;
    assign dt_ext = {{(MW-DW){temp_delta_reg[DW-1]}}, temp_delta_reg};
    assign dev    = {{(TW-FW){temp_first_order_reg[FW-1]}}, temp_first_order_reg}
                  - {{(TW-FW){1'b0}}, bscu_pkg::TEMP_REF};
    assign t_new  = $signed(prod[FW+22:23]) + bscu_pkg::TEMP_REF;
    assign p_fits = (acc_reg[AW-1:46] == {(AW-46){acc_reg[AW-1]}});

    bscu_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bscu_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = (sample.cmd == bscu_pkg::CMD_TEMP) ?
                                 bscu_pkg::ST_TMUL : bscu_pkg::ST_OFFMUL;
                end
            end
            bscu_pkg::ST_TMUL:   state_next = bscu_pkg::ST_TEMP;
            bscu_pkg::ST_TEMP:   state_next = bscu_pkg::ST_OUT;
            bscu_pkg::ST_OFFMUL: state_next = bscu_pkg::ST_OFF;
            bscu_pkg::ST_OFF:    state_next = bscu_pkg::ST_SENS;
            bscu_pkg::ST_SENS:   state_next = bscu_pkg::ST_AUX;
            bscu_pkg::ST_AUX:    state_next = bscu_pkg::ST_CORR;
            bscu_pkg::ST_CORR:   state_next = bscu_pkg::ST_PHI;
            bscu_pkg::ST_PHI:    state_next = bscu_pkg::ST_PLO;
            bscu_pkg::ST_PLO:    state_next = bscu_pkg::ST_PACC;
            bscu_pkg::ST_PACC:   state_next = bscu_pkg::ST_PSUB;
            bscu_pkg::ST_PSUB:   state_next = bscu_pkg::ST_PRES;
            bscu_pkg::ST_PRES:   state_next = bscu_pkg::ST_OUT;
            bscu_pkg::ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = bscu_pkg::ST_IDLE;
                end
            end
            default:             state_next = bscu_pkg::ST_IDLE;
        endcase
    end

    // handshake and multiplier operands
    always_comb
    begin
        sample.ready = 1'b0;
        result.valid = 1'b0;
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        case (state_reg)
            bscu_pkg::ST_IDLE: sample.ready = 1'b1;
            bscu_pkg::ST_TMUL:
            begin
                mul_en = 1'b1;
                mul_a  = dt_ext;
                mul_b  = {{(MW-CW){1'b0}}, coef.temp_slope_coef};
            end
            bscu_pkg::ST_OFFMUL:
            begin
                mul_en = 1'b1;
                mul_a  = dt_ext;
                mul_b  = {{(MW-CW){1'b0}}, coef.off_temp_coef};
            end
            bscu_pkg::ST_OFF:
            begin
                mul_en = 1'b1;
                mul_a  = dt_ext;
                mul_b  = {{(MW-CW){1'b0}}, coef.sens_temp_coef};
            end
            bscu_pkg::ST_SENS:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MW-TW){dev[TW-1]}}, dev};
                mul_b  = {{(MW-TW){dev[TW-1]}}, dev};
            end
            bscu_pkg::ST_AUX:
            begin
                mul_en = 1'b1;
                mul_a  = dt_ext;
                mul_b  = dt_ext;
            end
            bscu_pkg::ST_PHI:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MW-RW){1'b0}}, raw_reg};
                mul_b  = {{(MW-HW){sens_reg[WW-1]}}, sens_reg[WW-1:HW]};
            end
            bscu_pkg::ST_PLO:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MW-RW){1'b0}}, raw_reg};
                mul_b  = {{(MW-HW){1'b0}}, sens_reg[HW-1:0]};
            end
            bscu_pkg::ST_OUT: result.valid = 1'b1;
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        temp_delta_next       = temp_delta_reg;
        temp_first_order_next = temp_first_order_reg;
        temp_seen_next        = temp_seen_reg;
        raw_next              = raw_reg;
        off_next              = off_reg;
        sens_next             = sens_reg;
        aux5_next             = aux5_reg;
        t2_next               = t2_reg;
        acc_next              = acc_reg;
        out_kind_next         = out_kind_reg;
        out_temp_next         = out_temp_reg;
        out_press_next        = out_press_reg;
        out_flag_next         = out_flag_reg;
        case (state_reg)
            bscu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    raw_next = sample.raw_value;
                    if (sample.cmd == bscu_pkg::CMD_TEMP)
                    begin
                        temp_delta_next = {2'b00, sample.raw_value}
                                        - {2'b00, coef.ref_temp_coef, 8'd0};
                    end
                end
            end
            bscu_pkg::ST_TEMP:
            begin
                temp_first_order_next = t_new;
                temp_seen_next        = 1'b1;
                out_kind_next         = bscu_pkg::KIND_TEMP;
                out_temp_next         = {{(TW-FW){t_new[FW-1]}}, t_new};
                out_press_next        = '0;
                out_flag_next         = 1'b0;
            end
            bscu_pkg::ST_OFF:
            begin
                off_next = $signed({8'd0, coef.off_coef, 16'd0}) + $signed(prod[WW+6:7]);
            end
            bscu_pkg::ST_SENS:
            begin
                sens_next = $signed({9'd0, coef.sens_coef, 15'd0}) + $signed(prod[WW+7:8]);
            end
            bscu_pkg::ST_AUX:
            begin
                aux5_next = prod[WW-1:0] + {prod[WW-3:0], 2'b00};
            end
            bscu_pkg::ST_CORR:
            begin
                if (cold)
                begin
                    off_next  = off_reg - $signed({1'b0, aux5_reg[WW-1:1]});
                    sens_next = sens_reg - $signed({2'b00, aux5_reg[WW-1:2]});
                    t2_next   = prod[TW+30:31];
                end
                else
                begin
                    t2_next = '0;
                end
            end
            bscu_pkg::ST_PLO:
            begin
                acc_next = {prod[AW-HW-1:0], {HW{1'b0}}};
            end
            bscu_pkg::ST_PACC:
            begin
                acc_next = acc_reg + {{(AW-PW){prod[PW-1]}}, prod};
            end
            bscu_pkg::ST_PSUB:
            begin
                acc_next = {{21{acc_reg[AW-1]}}, acc_reg[AW-1:21]}
                         - {{(AW-WW){off_reg[WW-1]}}, off_reg};
            end
            bscu_pkg::ST_PRES:
            begin
                out_kind_next = bscu_pkg::KIND_PRESS;
                out_temp_next = {{(TW-FW){temp_first_order_reg[FW-1]}}, temp_first_order_reg}
                              - t2_reg;
                if (p_fits)
                begin
                    out_press_next = acc_reg[46:15];
                end
                else
                begin
                    out_press_next = acc_reg[AW-1] ? bscu_pkg::PRESS_MIN : bscu_pkg::PRESS_MAX;
                end
                out_flag_next = !temp_seen_reg;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= bscu_pkg::ST_IDLE;
            temp_delta_reg       <= '0;
            temp_first_order_reg <= bscu_pkg::TEMP_REF;
            temp_seen_reg        <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            temp_delta_reg       <= temp_delta_next;
            temp_first_order_reg <= temp_first_order_next;
            temp_seen_reg        <= temp_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg       <= raw_next;
        off_reg       <= off_next;
        sens_reg      <= sens_next;
        aux5_reg      <= aux5_next;
        t2_reg        <= t2_next;
        acc_reg       <= acc_next;
        out_kind_reg  <= out_kind_next;
        out_temp_reg  <= out_temp_next;
        out_press_reg <= out_press_next;
        out_flag_reg  <= out_flag_next;
    end

    assign result.kind               = out_kind_reg;
    assign result.temperature        = out_temp_reg;
    assign result.pressure           = out_press_reg;
    assign result.no_temperature_yet = out_flag_reg;

`ifndef SYNTHESIS
    a_ready_excl_valid: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !result.valid)
        else $error("input ready while a result is pending");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !result.valid)
        else $error("result presented in the cycle after acceptance");

    a_temp_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.kind == bscu_pkg::KIND_TEMP)) |->
        ((result.pressure == '0) && !result.no_temperature_yet))
        else $error("temperature result carries pressure or flag");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(temp_seen_reg))
        else $error("temperature-seen flag cleared");
`endif

endmodule

[hdl/baro_sensor_compensation_unit.sv]
// ----------------------------------------------------------------------------
// baro_sensor_compensation_unit
// Barometric sensor compensation: raw conversions to calibrated temperature
// and second-order corrected pressure.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. All products go through a
// single registered 27 x 27 multiplier that the sequencer issues once per
// step, and the input stays not ready until the result has been taken.
// Coefficients are to be written through cfg_wr_en / cfg_index / cfg_data
// only while no transaction is in flight; the unit does not enforce this.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bscu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bscu_pkg::COEF_W-1:0]       cfg_data,
    bscu_in_if.sink                           sample,
    bscu_out_if.source                        result
);

    bscu_pkg::coef_set_t coef;

    bscu_coef_regs u_coef_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coef     (coef)
    );

    bscu_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .coef   (coef),
        .sample (sample),
        .result (result)
    );

endmodule
